[design/afr_pkg.sv]
// ----------------------------------------------------------------------------
// afr_pkg: shared definitions for the addressed frame receiver
// Function codes, register map, hunt phase type and frame size default.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

    // default number of payload bytes per frame
    localparam int FRAME_BYTES_DEFAULT = 8;

    // width of a payload position field (read_index, cmd_pos)
    localparam int IDX_W = 3;

    // configuration port address width
    localparam int APB_AW = 5;

    // function codes carried in s_tuser
    localparam logic [1:0] FUNC_RECEIVE = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    // register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_HEADER_BYTE = 3'd0;
    localparam logic [2:0] REG_DEST_ID     = 3'd1;
    localparam logic [2:0] REG_SRC_ID      = 3'd2;
    localparam logic [2:0] REG_CMD_POS     = 3'd3;
    localparam logic [2:0] REG_CMD_VALUE   = 3'd4;

    // reset value of the command match register
    localparam logic [7:0] CMD_VALUE_RESET = 8'h05;

    // frame hunt phases
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_DEST   = 4'b0010,
        PH_SRC    = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

endpackage

`default_nettype wire

[design/addressed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// addressed_frame_receiver: byte-stream frame receiver with address match
// Hunts for header, destination and source bytes, stores the payload, checks
// a 16-bit sum carried in the last two bytes and keeps a sticky command flag.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one operation per item: s_tuser selects receive byte,
//   read payload byte or clear flag; s_tdata holds the byte and read index.
//   m_ channel returns exactly one result item per input item: acknowledge,
//   checksum result, status flag and read data, with m_tlast set on the item
//   that closes a frame (last payload byte).
//   The APB port sets header, destination, source, command position and
//   command value; write it only while no item is in flight.
// Flow:
//   an item is accepted into an input stage, processed in one pass of logic
//   and lands in the output register when the input stage advances; it
//   waits there while m_tready is low.
//   One item per cycle is sustained while m_tready stays high; the only loop
//   is the state and sum update of the processing stage.
// Reset: synchronous, active low; hunt returns to waiting for a header,
//   sum, count and flag clear, command value returns to 5. Payload storage
//   is not cleared.
// Stall: when m_tready is low the output register holds its item, the input
//   stage holds the next one, and s_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_frame_receiver #(
    parameter int FRAME_BYTES = afr_pkg::FRAME_BYTES_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    // input items
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [15:0]               s_tdata,  // rx_byte[7:0], read_index[10:8], zero
    input  wire logic [1:0]                s_tuser,  // func[1:0]

    // result items
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [15:0]                    m_tdata,  // send_ack[0], frame_good[1],
                                                     // status_flag[2], read_data[10:3], zero
    output logic                           m_tlast,  // frame_end

    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [afr_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // payload positions, and the part of the payload that can be read back
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int STORE_DEPTH = (FRAME_BYTES < 8) ? FRAME_BYTES : 8;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int IDX_W       = afr_pkg::IDX_W;

    // configuration registers
    logic [7:0]       header_byte_reg;
    logic [7:0]       dest_id_reg;
    logic [7:0]       src_id_reg;
    logic [IDX_W-1:0] cmd_pos_reg;
    logic [7:0]       cmd_value_reg;

    logic cfg_write;

    // input stage
    logic             st_valid_reg;
    logic [1:0]       st_func_reg;
    logic [7:0]       st_byte_reg;
    logic [IDX_W-1:0] st_idx_reg;
    logic [7:0]       rd_idx_data_reg;
    logic [7:0]       rd_cmd_data_reg;

    // frame state
    afr_pkg::phase_t  phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       prev_reg, prev_next;
    logic             flag_reg, flag_next;

    // payload memory
    logic [7:0]          payload_mem [STORE_DEPTH];
    logic                mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic [STORE_AW-1:0] rd_idx_addr;
    logic [STORE_AW-1:0] rd_cmd_addr;

    // output register
    logic       out_valid_reg;
    logic       out_ack_reg;
    logic       out_end_reg;
    logic       out_good_reg;
    logic       out_flag_reg;
    logic [7:0] out_data_reg;

    // processing results
    logic       res_ack;
    logic       res_end;
    logic       res_good;
    logic [7:0] res_data;

    logic s_accept;
    logic st_adv;
    logic pos_in_store;
    logic pos_last;
    logic pos_summed;
    logic idx_ok;
    logic cmd_ok;
    logic [7:0] cmd_byte;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_byte_reg <= '0;
            dest_id_reg     <= '0;
            src_id_reg      <= '0;
            cmd_pos_reg     <= '0;
            cmd_value_reg   <= afr_pkg::CMD_VALUE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                afr_pkg::REG_HEADER_BYTE: header_byte_reg <= pwdata[7:0];
                afr_pkg::REG_DEST_ID:     dest_id_reg     <= pwdata[7:0];
                afr_pkg::REG_SRC_ID:      src_id_reg      <= pwdata[7:0];
                afr_pkg::REG_CMD_POS:     cmd_pos_reg     <= pwdata[IDX_W-1:0];
                afr_pkg::REG_CMD_VALUE:   cmd_value_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            afr_pkg::REG_HEADER_BYTE: prdata = {24'd0, header_byte_reg};
            afr_pkg::REG_DEST_ID:     prdata = {24'd0, dest_id_reg};
            afr_pkg::REG_SRC_ID:      prdata = {24'd0, src_id_reg};
            afr_pkg::REG_CMD_POS:     prdata = {29'd0, cmd_pos_reg};
            afr_pkg::REG_CMD_VALUE:   prdata = {24'd0, cmd_value_reg};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign st_adv   = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_adv;
    assign s_accept = s_tvalid && s_tready;

    // input stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st_valid_reg <= s_tvalid;
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_func_reg <= s_tuser;
            st_byte_reg <= s_tdata[7:0];
            st_idx_reg  <= s_tdata[8 +: IDX_W];
        end
    end

    // ------------------------------------------------------------------
    // payload memory: one write port, two registered read ports
    // ------------------------------------------------------------------
    assign mem_waddr   = count_reg[STORE_AW-1:0];
    assign rd_idx_addr = s_tdata[8 +: STORE_AW];
    assign rd_cmd_addr = cmd_pos_reg[STORE_AW-1:0];

    // write the received payload byte
    always_ff @(posedge aclk) begin
        if (mem_we && st_adv) begin
            payload_mem[mem_waddr] <= st_byte_reg;
        end
    end

    // reads issued at accept, with the byte written in the same cycle forwarded
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (mem_we && st_adv && mem_waddr == rd_idx_addr) begin
                rd_idx_data_reg <= st_byte_reg;
            end else begin
                rd_idx_data_reg <= payload_mem[rd_idx_addr];
            end
            if (mem_we && st_adv && mem_waddr == rd_cmd_addr) begin
                rd_cmd_data_reg <= st_byte_reg;
            end else begin
                rd_cmd_data_reg <= payload_mem[rd_cmd_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // processing pass
    // ------------------------------------------------------------------
    assign pos_in_store = {1'b0, count_reg} < (CNT_W+1)'(STORE_DEPTH);
    assign pos_last     = count_reg == CNT_W'(FRAME_BYTES - 1);
    assign pos_summed   = count_reg < CNT_W'(FRAME_BYTES - 2);
    assign idx_ok       = {1'b0, st_idx_reg} < (IDX_W+1)'(STORE_DEPTH);
    assign cmd_ok       = {1'b0, cmd_pos_reg} < (IDX_W+1)'(STORE_DEPTH);

    // command byte may be the byte arriving right now
    assign cmd_byte = (pos_in_store && cmd_pos_reg[STORE_AW-1:0] == count_reg[STORE_AW-1:0])
                    ? st_byte_reg : rd_cmd_data_reg;

    // next state and result of the item in the input stage
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        flag_next  = flag_reg;
        mem_we     = 1'b0;
        res_ack    = 1'b0;
        res_end    = 1'b0;
        res_good   = 1'b0;
        res_data   = '0;
        unique case (st_func_reg)
            afr_pkg::FUNC_RECEIVE: begin
                unique case (phase_reg)
                    afr_pkg::PH_DATA: begin
                        mem_we    = pos_in_store;
                        prev_next = st_byte_reg;
                        if (pos_summed) begin
                            sum_next = sum_reg + {8'd0, st_byte_reg};
                        end
                        if (pos_last) begin
                            res_good = (prev_reg == sum_reg[15:8]) &&
                                       (st_byte_reg == sum_reg[7:0]);
                            res_ack  = res_good;
                            res_end  = 1'b1;
                            if (res_good && cmd_ok && cmd_byte == cmd_value_reg) begin
                                flag_next = 1'b1;
                            end
                            phase_next = afr_pkg::PH_HEADER;
                            count_next = '0;
                            sum_next   = '0;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    afr_pkg::PH_SRC: begin
                        if (st_byte_reg == src_id_reg) begin
                            phase_next = afr_pkg::PH_DATA;
                        end
                    end
                    afr_pkg::PH_DEST: begin
                        // a wrong destination byte may open a new header
                        if (st_byte_reg == dest_id_reg) begin
                            phase_next = afr_pkg::PH_SRC;
                        end else if (st_byte_reg == header_byte_reg) begin
                            phase_next = afr_pkg::PH_DEST;
                        end else begin
                            phase_next = afr_pkg::PH_HEADER;
                        end
                    end
                    afr_pkg::PH_HEADER: begin
                        if (st_byte_reg == header_byte_reg) begin
                            phase_next = afr_pkg::PH_DEST;
                        end
                    end
                    default: phase_next = afr_pkg::PH_HEADER;
                endcase
            end
            afr_pkg::FUNC_READ: begin
                res_data = idx_ok ? rd_idx_data_reg : 8'd0;
            end
            afr_pkg::FUNC_CLEAR: begin
                flag_next = 1'b0;
            end
            default: ;
        endcase
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= afr_pkg::PH_HEADER;
            count_reg <= '0;
            sum_reg   <= '0;
            flag_reg  <= 1'b0;
        end else if (st_adv) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            flag_reg  <= flag_next;
        end
    end

    // previous payload byte, holds the checksum high byte at frame end
    always_ff @(posedge aclk) begin
        if (st_adv) begin
            prev_reg <= prev_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (st_adv) begin
            out_ack_reg  <= res_ack;
            out_end_reg  <= res_end;
            out_good_reg <= res_good;
            out_flag_reg <= flag_next;
            out_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_end_reg;
    assign m_tdata  = {5'd0, out_data_reg, out_flag_reg, out_good_reg, out_ack_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // payload position only moves while receiving payload
    a_count_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> phase_reg == afr_pkg::PH_DATA)
        else $error("payload count nonzero outside payload phase");

    // running sum is zero outside the payload phase
    a_sum_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg != '0 |-> phase_reg == afr_pkg::PH_DATA)
        else $error("running sum nonzero outside payload phase");

    // an acknowledge only comes with a frame end
    a_ack_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ack_reg |-> out_end_reg)
        else $error("acknowledge without frame end");

    // the flag is only set by a good frame end
    a_flag_set: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(flag_reg) |-> $past(st_adv && res_end && res_good))
        else $error("status flag set outside a good frame end");

    // a clear operation leaves the flag low
    a_flag_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        st_adv && st_func_reg == afr_pkg::FUNC_CLEAR |=> !flag_reg)
        else $error("status flag not cleared");

endmodule

`default_nettype wire

[tb/tb_addressed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// tb_addressed_frame_receiver: self-checking bench for the frame receiver
// Drives a directed table and then random frames (good, broken, truncated)
// mixed with reads, flag clears and noise over several register settings.
// Every result item is checked against a cycle-free model of the receiver or
// an exact typed row, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_addressed_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN      = afr_pkg::FRAME_BYTES_DEFAULT;
    localparam int DUT_LATENCY    = 2;
    localparam int STALL_LIMIT    = 2000;
    localparam int REPORT_MAX     = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PASS = 110;
    localparam int DIR_ROWS       = 20;

    // code that no operation uses, answered with the flag only
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    typedef struct packed {
        logic       send_ack;
        logic       frame_end;
        logic       frame_good;
        logic       status_flag;
        logic [7:0] read_data;
    } rx_result_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic [2:0] read_index;
        logic       typed;
        rx_result_t want;
    } stim_row_t;

    // dut signals
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;  // rx_byte[7:0], read_index[10:8], zero
    logic [1:0]        s_tuser  = '0;  // func[1:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;        // send_ack[0], frame_good[1], status_flag[2],
                                       // read_data[10:3], zero
    logic              m_tlast;        // frame_end
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [afr_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // register shadow
    logic [7:0] cfg_header    = 8'h00;
    logic [7:0] cfg_dest      = 8'h00;
    logic [7:0] cfg_src       = 8'h00;
    logic [2:0] cfg_cmd_pos   = 3'd0;
    logic [7:0] cfg_cmd_value = afr_pkg::CMD_VALUE_RESET;

    // receiver model state
    afr_pkg::phase_t hunt_ph     = afr_pkg::PH_HEADER;
    logic [2:0]      byte_pos    = 3'd0;
    logic [15:0]     payload_sum = 16'h0000;
    logic [7:0]      payload_mem [FRAME_LEN];
    logic            cmd_flag    = 1'b0;

    // items sent but not yet accepted, and results still to come
    stim_row_t  items_in_flight [$];
    rx_result_t expected_results [$];
    int         results_due  = 0;
    int         mismatches   = 0;
    int         items_sent   = 0;
    int         idle_cycles  = 0;
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;

    stim_row_t  dir_rows [DIR_ROWS];

    addressed_frame_receiver #(
        .FRAME_BYTES(FRAME_LEN)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always #6 aclk = ~aclk;

    // receiver model: one item in, one result out
    function automatic rx_result_t frame_rx_predict(input logic [1:0] f,
                                                    input logic [7:0] rx,
                                                    input logic [2:0] idx);
        rx_result_t r;
        logic       good;
        r = '0;
        case (f)
            afr_pkg::FUNC_RECEIVE: begin
                case (hunt_ph)
                    afr_pkg::PH_DATA: begin
                        payload_mem[byte_pos] = rx;
                        if (int'(byte_pos) < FRAME_LEN - 2)
                            payload_sum = payload_sum + rx;
                        if (int'(byte_pos) == FRAME_LEN - 1) begin
                            good = payload_mem[FRAME_LEN-2] == payload_sum[15:8] &&
                                   payload_mem[FRAME_LEN-1] == payload_sum[7:0];
                            if (good && int'(cfg_cmd_pos) < FRAME_LEN &&
                                payload_mem[cfg_cmd_pos] == cfg_cmd_value)
                                cmd_flag = 1'b1;
                            r.send_ack   = good;
                            r.frame_end  = 1'b1;
                            r.frame_good = good;
                            hunt_ph      = afr_pkg::PH_HEADER;
                            byte_pos     = 3'd0;
                            payload_sum  = 16'h0000;
                        end else begin
                            byte_pos = byte_pos + 3'd1;
                        end
                    end
                    afr_pkg::PH_SRC: begin
                        // anything but the source id is dropped here
                        if (rx == cfg_src)
                            hunt_ph = afr_pkg::PH_DATA;
                    end
                    afr_pkg::PH_DEST: begin
                        // a wrong destination may itself open a new frame
                        if (rx == cfg_dest)
                            hunt_ph = afr_pkg::PH_SRC;
                        else if (rx == cfg_header)
                            hunt_ph = afr_pkg::PH_DEST;
                        else
                            hunt_ph = afr_pkg::PH_HEADER;
                    end
                    default: begin
                        if (rx == cfg_header)
                            hunt_ph = afr_pkg::PH_DEST;
                    end
                endcase
            end
            afr_pkg::FUNC_READ: begin
                if (int'(idx) < FRAME_LEN)
                    r.read_data = payload_mem[idx];
            end
            afr_pkg::FUNC_CLEAR: begin
                cmd_flag = 1'b0;
            end
            default: ;
        endcase
        r.status_flag = cmd_flag;
        return r;
    endfunction

    // stall driver for the result side
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // accept monitor: check results, queue predictions
    always @(posedge aclk) begin : accept_mon
        rx_result_t got;
        rx_result_t exp_r;
        rx_result_t pred;
        stim_row_t  item;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.send_ack    = m_tdata[0];
                got.frame_good  = m_tdata[1];
                got.status_flag = m_tdata[2];
                got.read_data   = m_tdata[10:3];
                got.frame_end   = m_tlast;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result item with nothing expected: tdata=%04h tlast=%0b",
                                 m_tdata, m_tlast);
                end else begin
                    exp_r = expected_results.pop_front();
                    results_due--;
                    if (got.send_ack !== exp_r.send_ack ||
                        got.frame_end !== exp_r.frame_end ||
                        got.frame_good !== exp_r.frame_good ||
                        got.status_flag !== exp_r.status_flag ||
                        got.read_data !== exp_r.read_data) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"mismatch exp ack=%0b end=%0b good=%0b flag=%0b ",
                                      "data=%02h got ack=%0b end=%0b good=%0b flag=%0b ",
                                      "data=%02h"},
                                     exp_r.send_ack, exp_r.frame_end, exp_r.frame_good,
                                     exp_r.status_flag, exp_r.read_data,
                                     got.send_ack, got.frame_end, got.frame_good,
                                     got.status_flag, got.read_data);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item = items_in_flight.pop_front();
                pred = frame_rx_predict(item.func, item.rx_byte, item.read_index);
                expected_results.push_back(item.typed ? item.want : pred);
                results_due++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_addressed_frame_receiver NOT OK");
            $finish;
        end
    end

    // one item on the input side, returns at the falling edge after accept
    task automatic send_item(input logic [1:0] f, input logic [7:0] rx,
                             input logic [2:0] idx, input logic typed,
                             input rx_result_t want);
        stim_row_t item;
        item = '{f, rx, idx, typed, want};
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {5'b00000, idx, rx};
        items_in_flight.push_back(item);
        items_sent++;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_rx(input logic [7:0] rx);
        send_item(afr_pkg::FUNC_RECEIVE, rx, 3'($urandom_range(7)), 1'b0, '0);
    endtask

    // stop sending until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (results_due == 0);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] reg_idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'h000000, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (reg_idx)
            afr_pkg::REG_HEADER_BYTE: cfg_header    = val;
            afr_pkg::REG_DEST_ID:     cfg_dest      = val;
            afr_pkg::REG_SRC_ID:      cfg_src       = val;
            afr_pkg::REG_CMD_POS:     cfg_cmd_pos   = val[2:0];
            afr_pkg::REG_CMD_VALUE:   cfg_cmd_value = val;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] hdr, input logic [7:0] dst,
                              input logic [7:0] src, input logic [2:0] pos,
                              input logic [7:0] cmd);
        cfg_write(afr_pkg::REG_HEADER_BYTE, hdr);
        cfg_write(afr_pkg::REG_DEST_ID, dst);
        cfg_write(afr_pkg::REG_SRC_ID, src);
        cfg_write(afr_pkg::REG_CMD_POS, {5'b00000, pos});
        cfg_write(afr_pkg::REG_CMD_VALUE, cmd);
    endtask

    // read, clear, reserved code or a stray byte
    task automatic send_misc();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            send_item(afr_pkg::FUNC_READ, 8'($urandom_range(255)),
                      3'($urandom_range(7)), 1'b0, '0);
        else if (pick < 75)
            send_item(afr_pkg::FUNC_CLEAR, 8'($urandom_range(255)),
                      3'($urandom_range(7)), 1'b0, '0);
        else if (pick < 85)
            send_item(FUNC_RESERVED, 8'($urandom_range(255)), 3'($urandom_range(7)),
                      1'b0, '0);
        else
            send_rx(8'($urandom_range(255)));
    endtask

    // frame with random payload; broken ones get a wrong destination,
    // a bad checksum byte or are cut short
    task automatic send_frame(input bit broken);
        logic [7:0]  p [FRAME_LEN];
        logic [15:0] s;
        int          kind;
        int          cut;
        kind = broken ? $urandom_range(2) : 3;
        send_rx(cfg_header);
        if (kind == 0)
            send_rx(8'($urandom_range(255)));
        else
            send_rx(cfg_dest);
        if ($urandom_range(99) < 15)
            send_rx(8'($urandom_range(255)));
        send_rx(cfg_src);
        for (int i = 0; i < FRAME_LEN - 2; i++)
            p[i] = 8'($urandom_range(255));
        if ($urandom_range(1) == 1 && int'(cfg_cmd_pos) < FRAME_LEN - 2)
            p[cfg_cmd_pos] = cfg_cmd_value;
        s = 16'h0000;
        for (int i = 0; i < FRAME_LEN - 3; i++)
            s = s + p[i];
        // steer the low sum byte onto the command value when it sits last
        if (int'(cfg_cmd_pos) == FRAME_LEN - 1 && $urandom_range(1) == 1)
            p[FRAME_LEN-3] = cfg_cmd_value - s[7:0];
        s = s + p[FRAME_LEN-3];
        p[FRAME_LEN-2] = s[15:8];
        p[FRAME_LEN-1] = s[7:0];
        if (kind == 1)
            p[FRAME_LEN-2+$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        cut = (kind == 2) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(99) < 8)
                send_misc();
            send_rx(p[i]);
        end
    endtask

    // main sequence
    initial begin
        int goal;
        int pick;
        for (int i = 0; i < FRAME_LEN; i++)
            payload_mem[i] = 8'h00;

        // directed table: typed rows are exact, the rest go to the model
        dir_rows = '{
            '{afr_pkg::FUNC_CLEAR,   8'h00, 3'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
            '{FUNC_RESERVED,         8'hFF, 3'd7, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
            '{afr_pkg::FUNC_RECEIVE, 8'hA5, 3'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
            '{afr_pkg::FUNC_RECEIVE, 8'hA5, 3'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
            '{afr_pkg::FUNC_RECEIVE, 8'h3C, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'hC3, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'hFF, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'h00, 3'd0, 1'b0, '0},
            '{afr_pkg::FUNC_RECEIVE, 8'hFF, 3'd0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 8'h00}},
            '{afr_pkg::FUNC_READ,    8'h00, 3'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'hFF}},
            '{afr_pkg::FUNC_READ,    8'h00, 3'd7, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'hFF}},
            '{afr_pkg::FUNC_READ,    8'hFF, 3'd1, 1'b0, '0},
            '{afr_pkg::FUNC_CLEAR,   8'hFF, 3'd7, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}}
        };

        // reset
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: distinct ids, command in the last payload slot
        set_config(8'hA5, 8'h3C, 8'hC3, 3'd7, 8'hFF);
        foreach (dir_rows[i])
            send_item(dir_rows[i].func, dir_rows[i].rx_byte, dir_rows[i].read_index,
                      dir_rows[i].typed, dir_rows[i].want);

        // random passes over register settings and idling modes
        for (int pass = 0; pass < RANDOM_PHASES; pass++) begin
            drain_results();
            case (pass % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            if (pass == 0)
                set_config(8'h00, 8'h00, 8'h00, 3'd0, 8'h00);
            else if (pass == 1)
                set_config(8'hFF, 8'hFF, 8'hFF, 3'd7, 8'hFF);
            else
                set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 3'($urandom_range(7)),
                           8'($urandom_range(255)));
            goal = items_sent + ITEMS_PER_PASS;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_frame(1'b0);
                else if (pick < 82)
                    send_frame(1'b1);
                else
                    send_misc();
                if ($urandom_range(99) < 4)
                    drain_results();
            end
        end

        // wind down
        s_tvalid <= 1'b0;
        wait (results_due == 0);
        repeat (DUT_LATENCY + 4) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_addressed_frame_receiver OK");
        else
            $display("tb_addressed_frame_receiver NOT OK");
        $finish;
    end

endmodule

[sim.f]
design/afr_pkg.sv
design/addressed_frame_receiver.sv
tb/tb_addressed_frame_receiver.sv
